FILE: rtl/ssr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

  // display geometry
  localparam int DIGIT_COUNT = 8;
  localparam int MAX_SEGMENT = 10;

  // payload field widths
  localparam int POS_W   = 3;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 4;
  localparam int SEG_W   = 4;
  localparam int VALUE_W = 27;

  // derived widths
  localparam int BCD_W   = 4 * DIGIT_COUNT;
  localparam int BND_W   = $clog2(2 * MAX_SEGMENT + 3);
  localparam int CMP_W   = (BND_W > ROW_W) ? BND_W : ROW_W;
  localparam int DCNT_W  = $clog2(DIGIT_COUNT + 1);
  localparam int PCMP_W  = (DCNT_W > POS_W) ? DCNT_W : POS_W;
  localparam int CNT_W   = $clog2(VALUE_W + 1);

  // register port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // segment bit positions in a mask
  localparam int SEG_A = 0;
  localparam int SEG_B = 1;
  localparam int SEG_C = 2;
  localparam int SEG_D = 3;
  localparam int SEG_E = 4;
  localparam int SEG_F = 5;
  localparam int SEG_G = 6;

  typedef enum logic {
    REG_SEGMENT_SIZE = 1'b0,
    REG_SHOWN_VALUE  = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    GLYPH_BLANK = 2'd0,
    GLYPH_HORIZ = 2'd1,
    GLYPH_VERT  = 2'd2
  } glyph_t;

  typedef struct packed {
    logic [POS_W-1:0] digit_position;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_column;
  } item_t;

  typedef struct packed {
    glyph_t glyph;
    logic   shown;
  } result_t;

  // converter status, bcd digit 0 is least significant
  typedef struct packed {
    logic                        busy;
    logic                        overflow;
    logic [DIGIT_COUNT-1:0][3:0] bcd;
  } bcd_status_t;

  // settings seen by the pipeline, digit indexed by cell position
  typedef struct packed {
    logic                        busy;
    logic [DIGIT_COUNT-1:0][3:0] digit;
    logic [DIGIT_COUNT-1:0]      displayed;
    logic [CMP_W-1:0]            s;
    logic [CMP_W-1:0]            s_p1;
    logic [CMP_W-1:0]            s_p2;
    logic [CMP_W-1:0]            s2_p1;
    logic [CMP_W-1:0]            s2_p2;
  } cfg_t;

  // lit segments of a decimal digit
  function automatic logic [6:0] seg_mask(input logic [3:0] digit);
    logic [6:0] m;
    case (digit)
      4'd0:    m = 7'h3F;
      4'd1:    m = 7'h06;
      4'd2:    m = 7'h5B;
      4'd3:    m = 7'h4F;
      4'd4:    m = 7'h66;
      4'd5:    m = 7'h6D;
      4'd6:    m = 7'h7D;
      4'd7:    m = 7'h07;
      4'd8:    m = 7'h7F;
      4'd9:    m = 7'h6F;
      default: m = 7'h00;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ssr_bcd.sv
`timescale 1ns / 1ps
`default_nettype none

module ssr_bcd (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire logic [ssr_pkg::VALUE_W-1:0] value,
  output ssr_pkg::bcd_status_t             status
);
  import ssr_pkg::*;

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   adj;
  logic [BCD_W-1:0]   bcd_next;
  logic               carry;
  logic               overflow;
  logic [CNT_W-1:0]   count;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
    {carry, bcd_next} = {adj, bin[VALUE_W-1]};
  end

  // one binary bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      bcd      <= '0;
      overflow <= 1'b0;
    end else if (load) begin
      count    <= CNT_W'(VALUE_W);
      bcd      <= '0;
      overflow <= 1'b0;
    end else if (count != '0) begin
      count    <= count - CNT_W'(1);
      bcd      <= bcd_next;
      overflow <= overflow | carry;
    end
  end

  // shift register for the binary input
  always_ff @(posedge clk) begin
    if (load) begin
      bin <= value;
    end else if (count != '0) begin
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end
  end

  assign status.busy     = (count != '0);
  assign status.overflow = overflow;
  assign status.bcd      = bcd;

endmodule

`default_nettype wire

FILE: rtl/ssr_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ssr_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssr_pkg::DATA_W-1:0] pwdata,
  output logic      [ssr_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output ssr_pkg::cfg_t                   cfg
);
  import ssr_pkg::*;

  logic [SEG_W-1:0]   segment_size;
  logic [VALUE_W-1:0] shown_value;
  reg_index_t         reg_sel;
  logic               wr;
  logic               load;
  bcd_status_t        conv;
  logic [CMP_W-1:0]   seg_ext;
  logic [CMP_W-1:0]   s_eff;
  logic               lead;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);
  assign wr      = psel & penable & pwrite;
  assign load    = wr & (reg_sel == REG_SHOWN_VALUE);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_size <= SEG_W'(2);
      shown_value  <= '0;
    end else if (wr) begin
      unique case (reg_sel)
        REG_SEGMENT_SIZE: segment_size <= pwdata[SEG_W-1:0];
        REG_SHOWN_VALUE:  shown_value  <= pwdata[VALUE_W-1:0];
        default:          ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_SEGMENT_SIZE: prdata = DATA_W'(segment_size);
      REG_SHOWN_VALUE:  prdata = DATA_W'(shown_value);
      default:          prdata = '0;
    endcase
  end

  // binary to decimal conversion after a value write
  ssr_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .value  (pwdata[VALUE_W-1:0]),
    .status (conv)
  );

  // clamp the stroke length, zero to one and anything above MAX_SEGMENT to MAX_SEGMENT
  always_comb begin
    seg_ext = CMP_W'(segment_size);
    if (seg_ext == '0) begin
      s_eff = CMP_W'(1);
    end else if (seg_ext > CMP_W'(MAX_SEGMENT)) begin
      s_eff = CMP_W'(MAX_SEGMENT);
    end else begin
      s_eff = seg_ext;
    end
  end

  // digits by position, the leading-zero blanking mask and the bounds
  always_comb begin
    cfg.busy  = conv.busy;
    cfg.s     = s_eff;
    cfg.s_p1  = s_eff + CMP_W'(1);
    cfg.s_p2  = s_eff + CMP_W'(2);
    cfg.s2_p1 = {s_eff[CMP_W-2:0], 1'b0} + CMP_W'(1);
    cfg.s2_p2 = {s_eff[CMP_W-2:0], 1'b0} + CMP_W'(2);
    lead = conv.overflow;
    for (int p = 0; p < DIGIT_COUNT; p++) begin
      cfg.digit[p]     = conv.bcd[DIGIT_COUNT-1-p];
      lead             = lead | (conv.bcd[DIGIT_COUNT-1-p] != 4'd0);
      cfg.displayed[p] = lead | (p == DIGIT_COUNT - 1);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ssr_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module ssr_pipe (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ssr_pkg::cfg_t   cfg,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire ssr_pkg::item_t  item,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output ssr_pkg::result_t     result
);
  import ssr_pkg::*;

  // stage 1: digit lookup
  logic             v1;
  logic [6:0]       mask1;
  logic             disp1;
  logic [CMP_W-1:0] row1;
  logic [CMP_W-1:0] col1;

  // stage 2: geometry hits
  logic             v2;
  logic [6:0]       hit2;
  logic             shown2;

  // stage 3: output
  logic             v3;
  result_t          res3;

  logic             rdy1;
  logic             rdy2;
  logic             rdy3;
  logic             accept;

  logic [PCMP_W-1:0] pos_ext;
  logic              pos_ok;
  logic [3:0]        digit_sel;
  logic              disp_sel;

  logic in_cell, in_span, upper, lower;
  logic [6:0] hit_c;
  glyph_t glyph_c;

  // stall chain
  assign rdy3       = ~v3 | ~result_stall;
  assign rdy2       = ~v2 | rdy3;
  assign rdy1       = ~v1 | rdy2;
  assign item_stall = ~rdy1 | cfg.busy;
  assign accept     = item_valid & ~item_stall;

  // select the digit of the addressed cell
  always_comb begin
    pos_ext   = PCMP_W'(item.digit_position);
    pos_ok    = pos_ext < PCMP_W'(DIGIT_COUNT);
    digit_sel = 4'd0;
    disp_sel  = 1'b0;
    for (int p = 0; p < DIGIT_COUNT; p++) begin
      if (pos_ext == PCMP_W'(p)) begin
        digit_sel = cfg.digit[p];
        disp_sel  = cfg.displayed[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mask1 <= seg_mask(digit_sel);
      disp1 <= pos_ok & disp_sel;
      row1  <= CMP_W'(item.cell_row);
      col1  <= CMP_W'(item.cell_column);
    end
  end

  // row and column against the segment bounds
  always_comb begin
    in_cell = (row1 <= cfg.s2_p2) && (col1 <= cfg.s_p2);
    in_span = (col1 >= CMP_W'(1)) && (col1 <= cfg.s);
    upper   = (row1 >= CMP_W'(1)) && (row1 <= cfg.s);
    lower   = (row1 >= cfg.s_p2) && (row1 <= cfg.s2_p1);
    hit_c[SEG_A] = in_span && (row1 == '0) && mask1[SEG_A];
    hit_c[SEG_G] = in_span && (row1 == cfg.s_p1) && mask1[SEG_G];
    hit_c[SEG_D] = in_span && (row1 == cfg.s2_p2) && mask1[SEG_D];
    hit_c[SEG_F] = (col1 == '0) && upper && mask1[SEG_F];
    hit_c[SEG_E] = (col1 == '0) && lower && mask1[SEG_E];
    hit_c[SEG_B] = (col1 == cfg.s_p1) && upper && mask1[SEG_B];
    hit_c[SEG_C] = (col1 == cfg.s_p1) && lower && mask1[SEG_C];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      hit2   <= hit_c;
      shown2 <= disp1 & in_cell;
    end
  end

  // horizontal strokes win over vertical ones
  always_comb begin
    if (!shown2) begin
      glyph_c = GLYPH_BLANK;
    end else if (hit2[SEG_A] | hit2[SEG_G] | hit2[SEG_D]) begin
      glyph_c = GLYPH_HORIZ;
    end else if (hit2[SEG_F] | hit2[SEG_E] | hit2[SEG_B] | hit2[SEG_C]) begin
      glyph_c = GLYPH_VERT;
    end else begin
      glyph_c = GLYPH_BLANK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      res3.glyph <= glyph_c;
      res3.shown <= shown2;
    end
  end

  assign result_valid = v3;
  assign result       = res3;

endmodule

`default_nettype wire

FILE: rtl/scaled_seven_segment_renderer.sv
// an accepted beat passes the stage 1, 2 and 3 registers to its result beat
// one beat per cycle unless stalled; three pipeline stages hold one beat each
// a write to shown_value starts a binary to decimal conversion, one
//   bit per cycle, during which input beats are stalled
// reset (rst, synchronous, active high): segment_size 2, shown_value 0,
//   pipeline empty, no conversion running
`timescale 1ns / 1ps
`default_nettype none

module scaled_seven_segment_renderer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssr_pkg::DATA_W-1:0] pwdata,
  output logic      [ssr_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire ssr_pkg::item_t             item,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output ssr_pkg::result_t                result
);
  import ssr_pkg::*;

  cfg_t cfg;

  // register port and digit conversion
  ssr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // glyph pipeline
  ssr_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ssr_pkg::*;

  // lit segments per decimal digit, bit SEG_A .. SEG_G
  localparam bit [6:0] DIGIT_LIT [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };
  localparam int unsigned VALUE_MAX = (1 << VALUE_W) - 1;

  typedef struct {
    logic [SEG_W-1:0]   size;
    logic [VALUE_W-1:0] value;
    item_t              point;
    bit                 typed;
    result_t            want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  // register copies seen by the predictor
  logic [SEG_W-1:0]   seg_len_reg = 4'd2;
  logic [VALUE_W-1:0] value_reg = '0;

  result_t   pending_points [$];
  plan_row_t plan [$];
  int        mismatches = 0;
  bit        calm = 1'b0;
  bit        cur_typed = 1'b0;
  result_t   cur_want;
  result_t   head;

  scaled_seven_segment_renderer dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #6 clk = ~clk;

  // stroke length actually drawn for a register value
  function automatic int unsigned drawn_size(input logic [SEG_W-1:0] size);
    int unsigned s;
    s = size;
    if (s < 1) s = 1;
    if (s > MAX_SEGMENT) s = MAX_SEGMENT;
    return s;
  endfunction

  // glyph and shown flag at one point of the digit row
  function automatic result_t render_point(input item_t pt, input logic [SEG_W-1:0] size,
                                           input logic [VALUE_W-1:0] value);
    int unsigned s, v, t, len, pos, r, c, digit;
    bit [6:0] lit;
    bit span, upper, lower;
    result_t res;
    s = drawn_size(size);
    v = value;
    res.glyph = GLYPH_BLANK;
    res.shown = 1'b0;
    // count decimal digits, zero still takes one cell
    len = 0;
    t = v;
    while (t != 0) begin
      len++;
      t = t / 10;
    end
    if (len < 1) len = 1;
    if (len > DIGIT_COUNT) len = DIGIT_COUNT;
    pos = pt.digit_position;
    r = pt.cell_row;
    c = pt.cell_column;
    if (pos < DIGIT_COUNT && pos >= DIGIT_COUNT - len && r <= 2 * s + 2 && c <= s + 2) begin
      t = v;
      for (int i = 0; i < DIGIT_COUNT - 1 - pos; i++) t = t / 10;
      digit = t % 10;
      lit = DIGIT_LIT[digit];
      res.shown = 1'b1;
      span = (c >= 1 && c <= s);
      upper = (r >= 1 && r <= s);
      lower = (r >= s + 2 && r <= 2 * s + 1);
      if (span && ((r == 0 && lit[SEG_A]) || (r == s + 1 && lit[SEG_G]) ||
                   (r == 2 * s + 2 && lit[SEG_D]))) begin
        res.glyph = GLYPH_HORIZ;
      end else if ((c == 0 && ((upper && lit[SEG_F]) || (lower && lit[SEG_E]))) ||
                   (c == s + 1 && ((upper && lit[SEG_B]) || (lower && lit[SEG_C])))) begin
        res.glyph = GLYPH_VERT;
      end
    end
    return res;
  endfunction

  task automatic note(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // scoreboard: input beats queue a prediction, result beats pop and compare
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        if (cur_typed) pending_points.push_back(cur_want);
        else pending_points.push_back(render_point(item, seg_len_reg, value_reg));
      end
      if (result_valid && !result_stall) begin
        if (pending_points.size() == 0) begin
          note($sformatf("result beat glyph %0d shown %0b with nothing pending",
                         result.glyph, result.shown));
        end else begin
          head = pending_points.pop_front();
          if (result.glyph !== head.glyph || result.shown !== head.shown) begin
            note($sformatf("expected glyph %0d shown %0b, got glyph %0d shown %0b",
                           head.glyph, head.shown, result.glyph, result.shown));
          end
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    result_stall <= !calm && ($urandom_range(99) < 23);
  end

  // one register write, setup then access phase
  task automatic set_register(input reg_index_t idx, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SEGMENT_SIZE: seg_len_reg = data[SEG_W-1:0];
      REG_SHOWN_VALUE:  value_reg = data[VALUE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_both(input logic [SEG_W-1:0] size, input logic [VALUE_W-1:0] value);
    logic [DATA_W-1:0] data;
    data = $urandom();
    data[SEG_W-1:0] = size;
    set_register(REG_SEGMENT_SIZE, data);
    data = $urandom();
    data[VALUE_W-1:0] = value;
    set_register(REG_SHOWN_VALUE, data);
  endtask

  // stop sending and let every pending result come out
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // one input beat, entered and left at a falling edge
  task automatic send_point(input item_t pt, input bit typed, input result_t want);
    while (!calm && $urandom_range(99) < 23) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    cur_typed = typed;
    cur_want = want;
    item <= pt;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    @(negedge clk);
  endtask

  task automatic plan_point(input logic [SEG_W-1:0] size, input logic [VALUE_W-1:0] value,
                            input int p, input int r, input int c, input bit typed,
                            input glyph_t g, input logic sh);
    plan_row_t e;
    e.size = size;
    e.value = value;
    e.point.digit_position = POS_W'(p);
    e.point.cell_row = ROW_W'(r);
    e.point.cell_column = COL_W'(c);
    e.typed = typed;
    e.want.glyph = g;
    e.want.shown = sh;
    plan.push_back(e);
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    item_t pt;
    int unsigned s, lo, hi, d;
    logic [SEG_W-1:0] size;
    logic [VALUE_W-1:0] value;

    // reset values: single zero in the rightmost cell
    plan_point(2, 0, 7, 0, 1, 1, GLYPH_HORIZ, 1'b1);
    plan_point(2, 0, 6, 0, 1, 1, GLYPH_BLANK, 1'b0);   // leading zero
    plan_point(2, 0, 7, 1, 0, 1, GLYPH_VERT, 1'b1);
    plan_point(2, 0, 7, 3, 1, 1, GLYPH_BLANK, 1'b1);   // no middle bar in zero
    plan_point(2, 0, 7, 2, 4, 1, GLYPH_BLANK, 1'b1);   // separator column
    plan_point(2, 0, 7, 6, 2, 1, GLYPH_HORIZ, 1'b1);
    plan_point(2, 0, 7, 7, 0, 1, GLYPH_BLANK, 1'b0);   // row past the cell
    plan_point(2, 0, 7, 0, 5, 1, GLYPH_BLANK, 1'b0);   // column past the cell
    plan_point(2, 0, 0, 31, 15, 1, GLYPH_BLANK, 1'b0);
    // smallest stroke, and size zero drawn as one
    plan_point(1, 8, 7, 2, 1, 1, GLYPH_HORIZ, 1'b1);
    plan_point(1, 8, 7, 3, 2, 1, GLYPH_VERT, 1'b1);
    plan_point(1, 8, 7, 4, 1, 1, GLYPH_HORIZ, 1'b1);
    plan_point(0, 8, 7, 2, 1, 1, GLYPH_HORIZ, 1'b1);
    // largest stroke, all eight cells filled
    plan_point(10, 99999999, 0, 0, 1, 1, GLYPH_HORIZ, 1'b1);
    plan_point(10, 99999999, 0, 22, 10, 1, GLYPH_HORIZ, 1'b1);
    plan_point(10, 99999999, 0, 12, 11, 1, GLYPH_VERT, 1'b1);
    plan_point(10, 99999999, 0, 23, 0, 1, GLYPH_BLANK, 1'b0);
    plan_point(10, 99999999, 3, 11, 12, 1, GLYPH_BLANK, 1'b1);
    // size above range, value with nine digits
    plan_point(15, VALUE_MAX, 0, 0, 1, 0, GLYPH_BLANK, 1'b0);
    plan_point(15, VALUE_MAX, 0, 22, 12, 0, GLYPH_BLANK, 1'b0);
    plan_point(15, VALUE_MAX, 7, 12, 0, 0, GLYPH_BLANK, 1'b0);
    // exactly eight digits with inner zeros, then seven digits with a blank leading cell
    plan_point(10, 10000000, 0, 11, 0, 0, GLYPH_BLANK, 1'b0);
    plan_point(10, 10000000, 1, 22, 5, 0, GLYPH_BLANK, 1'b0);
    plan_point(3, 1234567, 0, 0, 1, 1, GLYPH_BLANK, 1'b0);
    plan_point(3, 1234567, 1, 4, 4, 0, GLYPH_BLANK, 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows
    foreach (plan[i]) begin
      if (plan[i].size !== seg_len_reg || plan[i].value !== value_reg) begin
        wait_drained();
        write_both(plan[i].size, plan[i].value);
      end
      send_point(plan[i].point, plan[i].typed, plan[i].want);
    end

    // random phases, one setting each
    for (int phase = 0; phase < 16; phase++) begin
      wait_drained();
      case (phase)
        0: size = 4'd1;
        1: size = 4'd10;
        2: size = 4'd0;
        3: size = 4'd15;
        default: size = ($urandom_range(3) == 0) ? SEG_W'($urandom_range(15))
                                                  : SEG_W'($urandom_range(4, 1));
      endcase
      case (phase)
        0: value = '0;
        1: value = VALUE_MAX;
        2: value = 99999999;
        3: value = 12;
        default: begin
          d = $urandom_range(9, 1);
          lo = 1;
          repeat (d - 1) lo = lo * 10;
          hi = lo * 10 - 1;
          if (hi > VALUE_MAX) hi = VALUE_MAX;
          value = VALUE_W'($urandom_range(hi, lo));
        end
      endcase
      write_both(size, value);
      calm = (phase == 6);
      s = drawn_size(size);
      for (int n = 0; n < 96; n++) begin
        // sender holds off until the pipeline is empty
        if (phase == 8 && n == 48) wait_drained();
        pt.digit_position = POS_W'($urandom_range(DIGIT_COUNT - 1));
        pt.cell_row = ($urandom_range(99) < 85) ? ROW_W'($urandom_range(2 * s + 2))
                                                 : ROW_W'($urandom_range(31));
        pt.cell_column = ($urandom_range(99) < 85) ? COL_W'($urandom_range(s + 2))
                                                    : COL_W'($urandom_range(15));
        send_point(pt, 1'b0, '{GLYPH_BLANK, 1'b0});
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
